### rtl/assert_macros.svh
// assertion macros used by the rtl top
// needs a clk and an active-low arst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is held
`define CHK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked on every rising edge, off while reset is held
`define CHK_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/stt_pkg.sv
// types, codes and byte-class helpers for the source text tokenizer
// no dependencies
package stt_pkg;

	localparam int OFF_W  = 32;
	localparam int LINE_W = 24;
	localparam int COL_W  = 16;
	localparam int LEN_W  = 32;

	localparam logic [OFF_W-1:0]  OFF_MAX  = {OFF_W{1'b1}};
	localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
	localparam logic [COL_W-1:0]  COL_MAX  = {COL_W{1'b1}};

	localparam logic [2:0] UNICODE_DIGITS = 3'd4;
	localparam logic [7:0] CONTROL_LIMIT  = 8'h20;

	// token kinds
	localparam logic [4:0] K_NEWLINE = 5'd0;
	localparam logic [4:0] K_COMMENT = 5'd1;
	localparam logic [4:0] K_IDENT   = 5'd2;
	localparam logic [4:0] K_NUMBER  = 5'd3;
	localparam logic [4:0] K_STRING  = 5'd4;
	localparam logic [4:0] K_DOT     = 5'd5;
	localparam logic [4:0] K_COMMA   = 5'd6;
	localparam logic [4:0] K_COLON   = 5'd7;
	localparam logic [4:0] K_PLUS    = 5'd8;
	localparam logic [4:0] K_MINUS   = 5'd9;
	localparam logic [4:0] K_STAR    = 5'd10;
	localparam logic [4:0] K_SLASH   = 5'd11;
	localparam logic [4:0] K_LPAREN  = 5'd12;
	localparam logic [4:0] K_RPAREN  = 5'd13;
	localparam logic [4:0] K_LBRACK  = 5'd14;
	localparam logic [4:0] K_RBRACK  = 5'd15;
	localparam logic [4:0] K_INVALID = 5'd16;
	localparam logic [4:0] K_EOF     = 5'd17;

	// record types
	localparam logic RT_TOKEN = 1'b0;
	localparam logic RT_DIAG  = 1'b1;

	// characters
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_LOW_E = 8'h65;
	localparam logic [7:0] CH_UP_E  = 8'h45;
	localparam logic [7:0] CH_LOW_U = 8'h75;

	typedef enum logic [2:0] {
		D_UNEXPECTED   = 3'd0,
		D_UNTERMINATED = 3'd1,
		D_CONTROL      = 3'd2,
		D_INCOMPLETE   = 3'd3,
		D_SHORT_U      = 3'd4,
		D_UNSUPPORTED  = 3'd5,
		D_EXPONENT     = 3'd6
	} diag_t;

	// the last four modes are short follow-up steps that emit a pending record
	typedef enum logic [3:0] {
		M_IDLE, M_COMMENT, M_IDENT, M_INT, M_FRAC, M_EXP, M_EXPSIGN, M_EXPDIG,
		M_STR, M_ESC, M_UHEX, M_UNT_DIAG, M_UNT_TOK, M_INV_DIAG, M_EXPF_TOK
	} mode_t;

	typedef struct packed {
		logic              record_type;
		logic [4:0]        token_kind;
		logic [2:0]        diag_code;
		logic [OFF_W-1:0]  start_offset;
		logic [LEN_W-1:0]  token_length;
		logic [LINE_W-1:0] line_no;
		logic [COL_W-1:0]  column_no;
		logic [LINE_W-1:0] end_line_no;
		logic [COL_W-1:0]  end_column_no;
		logic [7:0]        offending_char;
		logic              last_of_run;
	} rec_t;

	function automatic logic is_dig(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
	endfunction

	function automatic logic is_hexd(input logic [7:0] c);
		return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_alpha(c) || is_dig(c) || (c == CH_UNDER);
	endfunction

	function automatic logic is_eol(input logic [7:0] c);
		return (c == CH_CR) || (c == CH_LF);
	endfunction

	// quote, backslash, slash, b f n r t
	function automatic logic in_simple(input logic [7:0] c);
		return c inside {8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74};
	endfunction

	function automatic logic [4:0] punct_kind(input logic [7:0] c);
		logic [4:0] k;
		case (c)
			8'h2e:   k = K_DOT;
			8'h2c:   k = K_COMMA;
			8'h3a:   k = K_COLON;
			8'h2b:   k = K_PLUS;
			8'h2d:   k = K_MINUS;
			8'h2a:   k = K_STAR;
			8'h2f:   k = K_SLASH;
			8'h28:   k = K_LPAREN;
			8'h29:   k = K_RPAREN;
			8'h5b:   k = K_LBRACK;
			8'h5d:   k = K_RBRACK;
			default: k = K_INVALID;
		endcase
		return k;
	endfunction

	function automatic logic is_trans(input mode_t m);
		return (m == M_UNT_DIAG) || (m == M_UNT_TOK) || (m == M_INV_DIAG) || (m == M_EXPF_TOK);
	endfunction

	function automatic logic [OFF_W-1:0] inc_off(input logic [OFF_W-1:0] a);
		return (a == OFF_MAX) ? a : a + OFF_W'(1);
	endfunction

	function automatic logic [OFF_W-1:0] add2_off(input logic [OFF_W-1:0] a);
		return (a >= OFF_MAX - OFF_W'(1)) ? OFF_MAX : a + OFF_W'(2);
	endfunction

	function automatic logic [LINE_W-1:0] inc_line(input logic [LINE_W-1:0] a);
		return (a == LINE_MAX) ? a : a + LINE_W'(1);
	endfunction

	function automatic logic [COL_W-1:0] inc_col(input logic [COL_W-1:0] a);
		return (a == COL_MAX) ? a : a + COL_W'(1);
	endfunction

	function automatic logic [COL_W-1:0] add_col(input logic [COL_W-1:0] a,
		input logic [COL_W-1:0] b);
		logic [COL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COL_W] ? COL_MAX : s[COL_W-1:0];
	endfunction

	function automatic rec_t mk_token(input logic [4:0] kind, input logic [OFF_W-1:0] ts_off,
		input logic [OFF_W-1:0] off, input logic [LINE_W-1:0] ln, input logic [COL_W-1:0] col,
		input logic [LINE_W-1:0] eln, input logic [COL_W-1:0] ecol);
		rec_t r;
		r = '0;
		r.record_type   = RT_TOKEN;
		r.token_kind    = kind;
		r.start_offset  = ts_off;
		r.token_length  = LEN_W'(off - ts_off);
		r.line_no       = ln;
		r.column_no     = col;
		r.end_line_no   = eln;
		r.end_column_no = ecol;
		return r;
	endfunction

	function automatic rec_t mk_diag(input diag_t code, input logic [OFF_W-1:0] ts_off,
		input logic [LINE_W-1:0] ln, input logic [COL_W-1:0] col, input logic [7:0] offend);
		rec_t r;
		r = '0;
		r.record_type    = RT_DIAG;
		r.diag_code      = code;
		r.start_offset   = ts_off;
		r.line_no        = ln;
		r.column_no      = col;
		r.end_line_no    = ln;
		r.end_column_no  = col;
		r.offending_char = offend;
		return r;
	endfunction

endpackage

### rtl/source_text_tokenizer_top.sv
// source text tokenizer: byte stream in, token and diagnostic requests out
// depends on stt_pkg and assert_macros.svh

// Takes one source byte per request (or an end-of-source request that flushes the
// token in progress and emits end-of-file) and gives token and diagnostic records
// with offset, length and line/column positions. Up to two bytes are held back as
// lookahead. A scan engine works on a small window (lookahead plus the new byte)
// and makes one decision per cycle while the queue has room, each yielding at most
// one record; the next request is taken as soon as one finishes, so plain text
// streams at one byte per cycle while the queue has room. Closing a token ahead of
// the byte that ends it, each further record and each further decision over
// held-back bytes costs a further decision. Records pass through a four-entry
// output queue; the engine pauses while fewer than two entries are free.
// last_of_run marks the final record caused by one request.
`include "assert_macros.svh"

module source_text_tokenizer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        src_valid,
	output logic                        src_ready,
	input  logic [7:0]                  ch,
	input  logic                        end_of_source,
	output logic                        rec_valid,
	input  logic                        rec_ready,
	output logic                        record_type,
	output logic [4:0]                  token_kind,
	output logic [2:0]                  diag_code,
	output logic [stt_pkg::OFF_W-1:0]   start_offset,
	output logic [stt_pkg::LEN_W-1:0]   token_length,
	output logic [stt_pkg::LINE_W-1:0]  line_no,
	output logic [stt_pkg::COL_W-1:0]   column_no,
	output logic [stt_pkg::LINE_W-1:0]  end_line_no,
	output logic [stt_pkg::COL_W-1:0]   end_column_no,
	output logic [7:0]                  offending_char,
	output logic                        last_of_run
);
	import stt_pkg::*;

	// scanner state
	mode_t             mode_q, n_mode;
	logic [7:0]        la0_q, la1_q;
	logic [1:0]        la_cnt_q;
	logic [OFF_W-1:0]  off_q, n_off, ts_off_q, n_ts_off;
	logic [LINE_W-1:0] line_q, n_line, ts_line_q, n_ts_line;
	logic [COL_W-1:0]  col_q, n_col, ts_col_q, n_ts_col;
	logic [COL_W-1:0]  esc_col_q, n_esc;
	logic [2:0]        hex_cnt_q, n_hex;
	logic [COL_W-1:0]  expo_q, n_expo;
	logic [7:0]        inv_ch_q, n_inv;

	// working window of the request in progress
	logic       busy_q, wend_q;
	logic [7:0] wb0_q, wb1_q, wb2_q;
	logic [1:0] rem_q, n_rem, cons, need, avail;
	logic       h1, h2;

	// record held back until it is known whether it closes the run
	logic held_vld_q;
	rec_t held_q;

	// output queue
	rec_t       ff_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	logic       act, stall, emit, early, eof_fin, fin, src_fire, pop;
	rec_t       rec, p0, p1;
	logic       p0v, p1v;
	logic [7:0] c, n1, n2, nwb0, nwb1, nwb2, la_nx0, la_nx1;
	logic [1:0] la_cnt_nx;
	logic [OFF_W-1:0] ediff;

	assign c  = wb0_q;
	assign n1 = wb1_q;
	assign n2 = wb2_q;
	assign h1 = (rem_q >= 2'd2);
	assign h2 = (rem_q == 2'd3);
	assign avail = rem_q - 2'd1;
	assign ediff = off_q - ts_off_q;

	assign stall = (cnt_q > 3'd2);
	assign act   = busy_q && !stall;

	// one scan decision per cycle, paused while the output queue is stalled
	always_comb begin
		n_mode = mode_q; n_off = off_q; n_line = line_q; n_col = col_q;
		n_ts_off = ts_off_q; n_ts_line = ts_line_q; n_ts_col = ts_col_q;
		n_esc = esc_col_q; n_hex = hex_cnt_q; n_expo = expo_q; n_inv = inv_ch_q;
		cons = 2'd0; emit = 1'b0; rec = '0; early = 1'b0; eof_fin = 1'b0;
		need = 2'd0;
		if (is_trans(mode_q)) begin
			// pending second half of an earlier decision
			emit   = 1'b1;
			n_mode = M_IDLE;
			case (mode_q)
				M_UNT_DIAG: begin
					rec    = mk_diag(D_UNTERMINATED, ts_off_q, ts_line_q, ts_col_q, 8'h00);
					n_mode = M_UNT_TOK;
				end
				M_UNT_TOK: begin
					rec = mk_token(K_STRING, ts_off_q, off_q, ts_line_q, ts_col_q, line_q, col_q);
				end
				M_INV_DIAG: begin
					rec = mk_diag(D_UNEXPECTED, ts_off_q, ts_line_q, ts_col_q, inv_ch_q);
				end
				default: begin
					rec = mk_token(K_NUMBER, ts_off_q, off_q, ts_line_q, ts_col_q, line_q, col_q);
				end
			endcase
		end else if (rem_q != 2'd0) begin
			case (mode_q)
				M_IDLE: begin
					if (c == CH_CR || c == CH_SLASH || c == CH_DOT || c == CH_MINUS)
						need = 2'd1;
					if (c == CH_MINUS && h1 && n1 == CH_DOT)
						need = 2'd2;
					if (avail < need && !wend_q) begin
						early = 1'b1;
					end else begin
						n_ts_off = off_q; n_ts_line = line_q; n_ts_col = col_q;
						if (c == CH_SPACE || c == CH_TAB) begin
							n_off = inc_off(off_q); n_col = inc_col(col_q); cons = 2'd1;
						end else if (is_eol(c)) begin
							if (c == CH_CR && h1 && n1 == CH_LF) begin
								n_off = add2_off(off_q); cons = 2'd2;
							end else begin
								n_off = inc_off(off_q); cons = 2'd1;
							end
							n_line = inc_line(line_q);
							n_col  = COL_W'(1);
							rec  = mk_token(K_NEWLINE, off_q, n_off, line_q, col_q, n_line, n_col);
							emit = 1'b1;
						end else begin
							n_off = inc_off(off_q); n_col = inc_col(col_q); cons = 2'd1;
							if (c == CH_HASH || (c == CH_SLASH && h1 && n1 == CH_SLASH)) begin
								n_mode = M_COMMENT;
							end else if (is_alpha(c) || c == CH_UNDER) begin
								n_mode = M_IDENT;
							end else if (is_dig(c) || (c == CH_MINUS && h1 &&
								(is_dig(n1) || (n1 == CH_DOT && h2 && is_dig(n2))))) begin
								n_mode = M_INT;
							end else if (c == CH_DOT && h1 && is_dig(n1)) begin
								n_mode = M_FRAC;
							end else if (c == CH_QUOTE) begin
								n_mode = M_STR;
							end else begin
								rec  = mk_token(punct_kind(c), off_q, n_off, line_q, col_q,
									line_q, n_col);
								emit = 1'b1;
								if (punct_kind(c) == K_INVALID) begin
									n_mode = M_INV_DIAG;
									n_inv  = c;
								end
							end
						end
					end
				end
				M_COMMENT, M_IDENT, M_EXPDIG: begin
					if ((mode_q == M_COMMENT) ? !is_eol(c) :
						(mode_q == M_IDENT) ? is_word(c) : is_dig(c)) begin
						n_off = inc_off(off_q); n_col = inc_col(col_q); cons = 2'd1;
					end else begin
						rec = mk_token((mode_q == M_COMMENT) ? K_COMMENT :
							(mode_q == M_IDENT) ? K_IDENT : K_NUMBER,
							ts_off_q, off_q, ts_line_q, ts_col_q, line_q, col_q);
						emit = 1'b1; n_mode = M_IDLE;
					end
				end
				M_INT, M_FRAC: begin
					if (is_dig(c)) begin
						n_off = inc_off(off_q); n_col = inc_col(col_q); cons = 2'd1;
					end else if (mode_q == M_INT && c == CH_DOT && !h1 && !wend_q) begin
						early = 1'b1;
					end else if (mode_q == M_INT && c == CH_DOT && h1 && is_dig(n1)) begin
						n_off = inc_off(off_q); n_col = inc_col(col_q); cons = 2'd1;
						n_mode = M_FRAC;
					end else if (c == CH_LOW_E || c == CH_UP_E) begin
						// exponent mark: remember its distance from the token start
						n_expo = (ediff > OFF_W'(COL_MAX)) ? COL_MAX : ediff[COL_W-1:0];
						n_off = inc_off(off_q); n_col = inc_col(col_q); cons = 2'd1;
						n_mode = M_EXP;
					end else begin
						rec = mk_token(K_NUMBER, ts_off_q, off_q, ts_line_q, ts_col_q, line_q, col_q);
						emit = 1'b1; n_mode = M_IDLE;
					end
				end
				M_EXP, M_EXPSIGN: begin
					if (mode_q == M_EXP && (c == CH_PLUS || c == CH_MINUS)) begin
						n_off = inc_off(off_q); n_col = inc_col(col_q); cons = 2'd1;
						n_mode = M_EXPSIGN;
					end else if (is_dig(c)) begin
						n_off = inc_off(off_q); n_col = inc_col(col_q); cons = 2'd1;
						n_mode = M_EXPDIG;
					end else begin
						rec = mk_diag(D_EXPONENT, ts_off_q, ts_line_q, add_col(ts_col_q, expo_q),
							8'h00);
						emit = 1'b1; n_mode = M_EXPF_TOK;
					end
				end
				M_STR: begin
					if (c == CH_QUOTE) begin
						n_off = inc_off(off_q); n_col = inc_col(col_q); cons = 2'd1;
						rec = mk_token(K_STRING, ts_off_q, n_off, ts_line_q, ts_col_q, line_q, n_col);
						emit = 1'b1; n_mode = M_IDLE;
					end else if (is_eol(c)) begin
						rec = mk_diag(D_UNTERMINATED, ts_off_q, ts_line_q, ts_col_q, 8'h00);
						emit = 1'b1; n_mode = M_UNT_TOK;
					end else if (c == CH_BSL) begin
						n_esc = col_q;
						n_off = inc_off(off_q); n_col = inc_col(col_q); cons = 2'd1;
						n_mode = M_ESC;
					end else begin
						if (c < CONTROL_LIMIT) begin
							rec  = mk_diag(D_CONTROL, ts_off_q, line_q, col_q, 8'h00);
							emit = 1'b1;
						end
						n_off = inc_off(off_q); n_col = inc_col(col_q); cons = 2'd1;
					end
				end
				M_ESC: begin
					if (is_eol(c)) begin
						rec = mk_diag(D_INCOMPLETE, ts_off_q, line_q, esc_col_q, 8'h00);
						emit = 1'b1; n_mode = M_UNT_DIAG;
					end else begin
						n_off = inc_off(off_q); n_col = inc_col(col_q); cons = 2'd1;
						n_mode = M_STR;
						if (c == CH_LOW_U) begin
							n_hex = 3'd0; n_mode = M_UHEX;
						end else if (!in_simple(c)) begin
							rec  = mk_diag(D_UNSUPPORTED, ts_off_q, line_q, esc_col_q, c);
							emit = 1'b1;
						end
					end
				end
				default: begin
					// unicode escape digits
					if (is_hexd(c) && hex_cnt_q < UNICODE_DIGITS) begin
						n_off = inc_off(off_q); n_col = inc_col(col_q); cons = 2'd1;
						n_hex = hex_cnt_q + 3'd1;
						if (n_hex >= UNICODE_DIGITS)
							n_mode = M_STR;
					end else begin
						rec = mk_diag(D_SHORT_U, ts_off_q, line_q, esc_col_q, 8'h00);
						emit = 1'b1; n_mode = M_STR;
					end
				end
			endcase
		end else if (wend_q) begin
			// end of source: flush the token in progress, then end-of-file
			emit   = 1'b1;
			n_mode = M_IDLE;
			case (mode_q)
				M_COMMENT: rec = mk_token(K_COMMENT, ts_off_q, off_q, ts_line_q, ts_col_q,
					line_q, col_q);
				M_IDENT: rec = mk_token(K_IDENT, ts_off_q, off_q, ts_line_q, ts_col_q,
					line_q, col_q);
				M_INT, M_FRAC, M_EXPDIG: rec = mk_token(K_NUMBER, ts_off_q, off_q, ts_line_q,
					ts_col_q, line_q, col_q);
				M_EXP, M_EXPSIGN: begin
					rec = mk_diag(D_EXPONENT, ts_off_q, ts_line_q, add_col(ts_col_q, expo_q),
						8'h00);
					n_mode = M_EXPF_TOK;
				end
				M_STR: begin
					rec = mk_diag(D_UNTERMINATED, ts_off_q, ts_line_q, ts_col_q, 8'h00);
					n_mode = M_UNT_TOK;
				end
				M_ESC: begin
					rec = mk_diag(D_INCOMPLETE, ts_off_q, line_q, esc_col_q, 8'h00);
					n_mode = M_UNT_DIAG;
				end
				M_UHEX: begin
					rec = mk_diag(D_SHORT_U, ts_off_q, line_q, esc_col_q, 8'h00);
					n_mode = M_UNT_DIAG;
				end
				default: begin
					rec = mk_token(K_EOF, off_q, off_q, line_q, col_q, line_q, col_q);
					eof_fin = 1'b1;
				end
			endcase
		end
	end

	assign n_rem = rem_q - cons;
	assign fin   = early || eof_fin || (!wend_q && n_rem == 2'd0 && !is_trans(n_mode));

	// window after consuming bytes
	always_comb begin
		case (cons)
			2'd1: begin nwb0 = wb1_q; nwb1 = wb2_q; nwb2 = wb2_q; end
			2'd2: begin nwb0 = wb2_q; nwb1 = wb2_q; nwb2 = wb2_q; end
			default: begin nwb0 = wb0_q; nwb1 = wb1_q; nwb2 = wb2_q; end
		endcase
	end

	// lookahead left for the next request
	always_comb begin
		la_nx0 = la0_q; la_nx1 = la1_q; la_cnt_nx = la_cnt_q;
		if (act && fin) begin
			if (eof_fin) begin
				la_cnt_nx = 2'd0;
			end else begin
				la_nx0 = nwb0; la_nx1 = nwb1;
				la_cnt_nx = (n_rem > 2'd2) ? 2'd2 : n_rem;
			end
		end
	end

	assign src_ready = !busy_q || (act && fin);
	assign src_fire  = src_valid && src_ready;

	// queue pushes: the held record learns here whether it closes the run
	always_comb begin
		p0v = 1'b0; p1v = 1'b0; p0 = held_q; p1 = rec;
		p0.last_of_run = 1'b0;
		p1.last_of_run = 1'b1;
		if (act) begin
			if (emit) begin
				if (held_vld_q) begin
					p0v = 1'b1;
					p1v = fin;
				end else if (fin) begin
					p0v = 1'b1;
					p0  = p1;
				end
			end else if (fin && held_vld_q) begin
				p0v = 1'b1;
				p0.last_of_run = 1'b1;
			end
		end
	end

	assign rec_valid = (cnt_q != 3'd0);
	assign pop       = rec_valid && rec_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			la0_q <= 8'h00; la1_q <= 8'h00; la_cnt_q <= 2'd0;
			off_q <= '0; line_q <= LINE_W'(1); col_q <= COL_W'(1);
			ts_off_q <= '0; ts_line_q <= LINE_W'(1); ts_col_q <= COL_W'(1);
			esc_col_q <= COL_W'(1); hex_cnt_q <= 3'd0; expo_q <= '0; inv_ch_q <= 8'h00;
			busy_q <= 1'b0; wend_q <= 1'b0; rem_q <= 2'd0;
			held_vld_q <= 1'b0;
			wr_q <= 2'd0; rd_q <= 2'd0; cnt_q <= 3'd0;
		end else begin
			la0_q <= la_nx0; la1_q <= la_nx1; la_cnt_q <= la_cnt_nx;
			if (act) begin
				if (eof_fin) begin
					// text finished: back to the state after reset
					mode_q <= M_IDLE;
					off_q <= '0; line_q <= LINE_W'(1); col_q <= COL_W'(1);
					ts_off_q <= '0; ts_line_q <= LINE_W'(1); ts_col_q <= COL_W'(1);
					esc_col_q <= COL_W'(1); hex_cnt_q <= 3'd0; expo_q <= '0;
				end else begin
					mode_q <= n_mode;
					off_q <= n_off; line_q <= n_line; col_q <= n_col;
					ts_off_q <= n_ts_off; ts_line_q <= n_ts_line; ts_col_q <= n_ts_col;
					esc_col_q <= n_esc; hex_cnt_q <= n_hex; expo_q <= n_expo;
				end
				inv_ch_q <= n_inv;
				if (emit && !fin) begin
					held_vld_q <= 1'b1;
				end else if (fin) begin
					held_vld_q <= 1'b0;
				end
			end
			// a new request can only land when the current one finishes
			if (src_fire) begin
				busy_q <= 1'b1;
				wend_q <= end_of_source;
				rem_q  <= la_cnt_nx + {1'b0, !end_of_source};
			end else if (act) begin
				rem_q <= n_rem;
				if (fin)
					busy_q <= 1'b0;
			end
			wr_q  <= wr_q + 2'(p0v) + 2'(p1v);
			if (pop)
				rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(p0v) + 3'(p1v) - 3'(pop);
		end
	end

	// window and record payload
	always_ff @(posedge clk) begin
		if (src_fire) begin
			wb0_q <= (la_cnt_nx >= 2'd1) ? la_nx0 : ch;
			wb1_q <= (la_cnt_nx >= 2'd2) ? la_nx1 : ch;
			wb2_q <= ch;
		end else if (act) begin
			wb0_q <= nwb0; wb1_q <= nwb1; wb2_q <= nwb2;
		end
		if (act && emit && !fin)
			held_q <= rec;
		if (p0v)
			ff_q[wr_q] <= p0;
		if (p1v)
			ff_q[wr_q + 2'd1] <= p1;
	end

	assign record_type    = ff_q[rd_q].record_type;
	assign token_kind     = ff_q[rd_q].token_kind;
	assign diag_code      = ff_q[rd_q].diag_code;
	assign start_offset   = ff_q[rd_q].start_offset;
	assign token_length   = ff_q[rd_q].token_length;
	assign line_no        = ff_q[rd_q].line_no;
	assign column_no      = ff_q[rd_q].column_no;
	assign end_line_no    = ff_q[rd_q].end_line_no;
	assign end_column_no  = ff_q[rd_q].end_column_no;
	assign offending_char = ff_q[rd_q].offending_char;
	assign last_of_run    = ff_q[rd_q].last_of_run;

	// queue never overfills
	`CHK_ALWAYS(a_queue_bound, cnt_q <= 3'd4, "output queue overflow")
	// nothing held back between requests
	`CHK_IMPL(a_held_idle, !busy_q, !held_vld_q, "record held with no request in progress")
	// follow-up modes only live inside a request
	`CHK_IMPL(a_trans_busy, is_trans(mode_q), busy_q, "follow-up mode outside a request")

endmodule

### tb/source_text_tokenizer_top_tb.sv
// testbench for the source text tokenizer: directed, random and back-pressure byte streams
// own record predictor, scoreboard on every record; depends on stt_pkg and the rtl top
`timescale 1ns / 100ps

module source_text_tokenizer_top_tb;
	import stt_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam int RECS_PER_STEP = 6;

	// predictor scan modes, kept apart from the rtl encoding
	typedef enum int {
		S_IDLE, S_COMMENT, S_IDENT, S_INT, S_FRAC, S_EXP, S_EXPSIGN, S_EXPDIG,
		S_STR, S_ESC, S_UHEX
	} scan_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_ready;
	logic [7:0] ch = 8'h00;
	logic end_of_source = 1'b0;
	logic rec_valid;
	logic rec_ready = 1'b0;
	logic record_type;
	logic [4:0] token_kind;
	logic [2:0] diag_code;
	logic [OFF_W-1:0] start_offset;
	logic [LEN_W-1:0] token_length;
	logic [LINE_W-1:0] line_no;
	logic [COL_W-1:0] column_no;
	logic [LINE_W-1:0] end_line_no;
	logic [COL_W-1:0] end_column_no;
	logic [7:0] offending_char;
	logic last_of_run;

	source_text_tokenizer_top dut (.*);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// idle percentages and the receiver hold-off request, set by the test tasks
	int src_idle_pct = 0;
	int rcv_idle_pct = 0;
	int hold_len = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int items_sent = 0;
	int mismatches = 0;
	int cycles = 0;

	rec_t expected_recs[$];
	rec_t step_recs[$];

	// ---------------------------------------------------------------
	// predictor state
	// ---------------------------------------------------------------
	scan_e mode;
	logic [7:0] la_bytes[2];
	int la_n;
	logic [OFF_W-1:0] pos_off, ts_off;
	logic [LINE_W-1:0] pos_line, ts_line;
	logic [COL_W-1:0] pos_col, ts_col, esc_col, exp_dist;
	int hex_n;

	function automatic void clear_scan();
		mode = S_IDLE;
		la_bytes[0] = '0;
		la_bytes[1] = '0;
		la_n = 0;
		pos_off = '0;
		pos_line = LINE_W'(1);
		pos_col = COL_W'(1);
		ts_off = '0;
		ts_line = LINE_W'(1);
		ts_col = COL_W'(1);
		esc_col = COL_W'(1);
		hex_n = 0;
		exp_dist = '0;
	endfunction

	// byte classes
	function automatic bit digit_b(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit letter_b(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit hex_b(logic [7:0] c);
		return digit_b(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic bit word_b(logic [7:0] c);
		return letter_b(c) || digit_b(c) || c == CH_UNDER;
	endfunction

	function automatic bit eol_b(logic [7:0] c);
		return c == CH_CR || c == CH_LF;
	endfunction

	function automatic bit plain_escape(logic [7:0] c);
		return c == CH_QUOTE || c == CH_BSL || c == CH_SLASH || c == "b" || c == "f"
			|| c == "n" || c == "r" || c == "t";
	endfunction

	function automatic logic [4:0] punct_of(logic [7:0] c);
		case (c)
			".": return K_DOT;
			",": return K_COMMA;
			":": return K_COLON;
			"+": return K_PLUS;
			"-": return K_MINUS;
			"*": return K_STAR;
			"/": return K_SLASH;
			"(": return K_LPAREN;
			")": return K_RPAREN;
			"[": return K_LBRACK;
			"]": return K_RBRACK;
			default: return K_INVALID;
		endcase
	endfunction

	// saturating counters
	function automatic logic [OFF_W-1:0] off_up(logic [OFF_W-1:0] a);
		return (a == OFF_MAX) ? a : a + 1'b1;
	endfunction

	function automatic logic [COL_W-1:0] col_sum(logic [COL_W-1:0] a, logic [COL_W-1:0] b);
		logic [COL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COL_W] ? COL_MAX : s[COL_W-1:0];
	endfunction

	function automatic void add_rec(logic rt, logic [4:0] kind, logic [2:0] code,
		logic [OFF_W-1:0] so, logic [LEN_W-1:0] len, logic [LINE_W-1:0] l,
		logic [COL_W-1:0] c, logic [LINE_W-1:0] el, logic [COL_W-1:0] ec, logic [7:0] oc);
		rec_t r;
		// more than six records in one step are dropped
		if (step_recs.size() >= RECS_PER_STEP)
			return;
		r = '{rt, kind, code, so, len, l, c, el, ec, oc, 1'b0};
		step_recs = {step_recs, r};
	endfunction

	function automatic void token_rec(logic [4:0] kind);
		add_rec(RT_TOKEN, kind, '0, ts_off, pos_off - ts_off, ts_line, ts_col,
			pos_line, pos_col, '0);
	endfunction

	function automatic void diag_rec(diag_t code, logic [LINE_W-1:0] l, logic [COL_W-1:0] c,
		logic [7:0] oc);
		add_rec(RT_DIAG, '0, code, ts_off, '0, l, c, l, c, oc);
	endfunction

	function automatic void advance();
		pos_off = off_up(pos_off);
		pos_col = (pos_col == COL_MAX) ? pos_col : pos_col + 1'b1;
	endfunction

	function automatic void close_token(logic [4:0] kind);
		token_rec(kind);
		mode = S_IDLE;
	endfunction

	function automatic void exponent_bad();
		diag_rec(D_EXPONENT, ts_line, col_sum(ts_col, exp_dist), '0);
		close_token(K_NUMBER);
	endfunction

	function automatic void string_unclosed();
		diag_rec(D_UNTERMINATED, ts_line, ts_col, '0);
		close_token(K_STRING);
	endfunction

	function automatic void exponent_open();
		logic [OFF_W-1:0] d;
		d = pos_off - ts_off;
		exp_dist = (d > OFF_W'(COL_MAX)) ? COL_MAX : d[COL_W-1:0];
		advance();
		mode = S_EXP;
	endfunction

	// scans the window, returns how many bytes were consumed
	function automatic int scan_window(logic [7:0] w[3], int n, bit at_end);
		int p, avail, need, nl_len;
		bit h1, h2;
		logic [7:0] c, n1, n2;
		logic [4:0] k;
		p = 0;
		while (p < n) begin
			c = w[p];
			avail = n - p - 1;
			h1 = avail >= 1;
			h2 = avail >= 2;
			n1 = h1 ? w[p+1] : 8'h00;
			n2 = h2 ? w[p+2] : 8'h00;
			case (mode)
				S_IDLE: begin
					// cr, slash, dot and minus need to see what follows
					need = (c == CH_CR || c == CH_SLASH || c == CH_DOT || c == CH_MINUS) ? 1 : 0;
					if (c == CH_MINUS && h1 && n1 == CH_DOT)
						need = 2;
					if (avail < need && !at_end)
						return p;
					ts_off = pos_off;
					ts_line = pos_line;
					ts_col = pos_col;
					if (c == CH_SPACE || c == CH_TAB) begin
						advance();
						p++;
					end else if (eol_b(c)) begin
						nl_len = (c == CH_CR && h1 && n1 == CH_LF) ? 2 : 1;
						pos_off = off_up(pos_off);
						if (nl_len == 2)
							pos_off = off_up(pos_off);
						pos_line = (pos_line == LINE_MAX) ? pos_line : pos_line + 1'b1;
						pos_col = COL_W'(1);
						token_rec(K_NEWLINE);
						p += nl_len;
					end else if (c == CH_HASH || (c == CH_SLASH && h1 && n1 == CH_SLASH)) begin
						advance();
						p++;
						mode = S_COMMENT;
					end else if (letter_b(c) || c == CH_UNDER) begin
						advance();
						p++;
						mode = S_IDENT;
					end else if (digit_b(c) || (c == CH_MINUS && h1 &&
						(digit_b(n1) || (n1 == CH_DOT && h2 && digit_b(n2))))) begin
						advance();
						p++;
						mode = S_INT;
					end else if (c == CH_DOT && h1 && digit_b(n1)) begin
						advance();
						p++;
						mode = S_FRAC;
					end else if (c == CH_QUOTE) begin
						advance();
						p++;
						mode = S_STR;
					end else begin
						k = punct_of(c);
						advance();
						p++;
						token_rec(k);
						if (k == K_INVALID)
							diag_rec(D_UNEXPECTED, ts_line, ts_col, c);
					end
				end
				S_COMMENT: begin
					if (eol_b(c))
						close_token(K_COMMENT);
					else begin
						advance();
						p++;
					end
				end
				S_IDENT: begin
					if (word_b(c)) begin
						advance();
						p++;
					end else
						close_token(K_IDENT);
				end
				S_INT: begin
					if (digit_b(c)) begin
						advance();
						p++;
					end else if (c == CH_DOT) begin
						if (!h1 && !at_end)
							return p;
						if (h1 && digit_b(n1)) begin
							advance();
							p++;
							mode = S_FRAC;
						end else
							close_token(K_NUMBER);
					end else if (c == CH_LOW_E || c == CH_UP_E) begin
						exponent_open();
						p++;
					end else
						close_token(K_NUMBER);
				end
				S_FRAC: begin
					if (digit_b(c)) begin
						advance();
						p++;
					end else if (c == CH_LOW_E || c == CH_UP_E) begin
						exponent_open();
						p++;
					end else
						close_token(K_NUMBER);
				end
				S_EXP: begin
					if (c == CH_PLUS || c == CH_MINUS) begin
						advance();
						p++;
						mode = S_EXPSIGN;
					end else if (digit_b(c)) begin
						advance();
						p++;
						mode = S_EXPDIG;
					end else
						exponent_bad();
				end
				S_EXPSIGN: begin
					if (digit_b(c)) begin
						advance();
						p++;
						mode = S_EXPDIG;
					end else
						exponent_bad();
				end
				S_EXPDIG: begin
					if (digit_b(c)) begin
						advance();
						p++;
					end else
						close_token(K_NUMBER);
				end
				S_STR: begin
					if (c == CH_QUOTE) begin
						advance();
						p++;
						close_token(K_STRING);
					end else if (eol_b(c))
						string_unclosed();
					else if (c == CH_BSL) begin
						esc_col = pos_col;
						advance();
						p++;
						mode = S_ESC;
					end else begin
						if (c < CONTROL_LIMIT)
							diag_rec(D_CONTROL, pos_line, pos_col, '0);
						advance();
						p++;
					end
				end
				S_ESC: begin
					if (eol_b(c)) begin
						diag_rec(D_INCOMPLETE, pos_line, esc_col, '0);
						string_unclosed();
					end else if (plain_escape(c)) begin
						advance();
						p++;
						mode = S_STR;
					end else if (c == CH_LOW_U) begin
						advance();
						p++;
						hex_n = 0;
						mode = S_UHEX;
					end else begin
						diag_rec(D_UNSUPPORTED, pos_line, esc_col, c);
						advance();
						p++;
						mode = S_STR;
					end
				end
				default: begin
					// unicode escape digits
					if (hex_b(c) && hex_n < 4) begin
						advance();
						p++;
						hex_n++;
						if (hex_n >= 4)
							mode = S_STR;
					end else begin
						diag_rec(D_SHORT_U, pos_line, esc_col, '0);
						mode = S_STR;
					end
				end
			endcase
		end
		return p;
	endfunction

	function automatic void flush_token();
		case (mode)
			S_COMMENT: close_token(K_COMMENT);
			S_IDENT: close_token(K_IDENT);
			S_INT, S_FRAC, S_EXPDIG: close_token(K_NUMBER);
			S_EXP, S_EXPSIGN: exponent_bad();
			S_STR: string_unclosed();
			S_ESC: begin
				diag_rec(D_INCOMPLETE, pos_line, esc_col, '0);
				string_unclosed();
			end
			S_UHEX: begin
				diag_rec(D_SHORT_U, pos_line, esc_col, '0);
				string_unclosed();
			end
			default: ;
		endcase
		mode = S_IDLE;
	endfunction

	// works out the records of one accepted request and queues them
	function automatic void predict_records(logic [7:0] b, logic eos);
		logic [7:0] w[3];
		int n, p;
		step_recs.delete();
		w = '{default: 8'h00};
		n = la_n;
		for (int i = 0; i < n; i++)
			w[i] = la_bytes[i];
		if (!eos)
			w[n++] = b;
		p = scan_window(w, n, eos);
		if (eos) begin
			flush_token();
			add_rec(RT_TOKEN, K_EOF, '0, pos_off, '0, pos_line, pos_col, pos_line, pos_col,
				'0);
			clear_scan();
		end else begin
			la_n = 0;
			for (int i = p; i < n && la_n < 2; i++)
				la_bytes[la_n++] = w[i];
		end
		if (step_recs.size() > 0)
			step_recs[step_recs.size()-1].last_of_run = 1'b1;
		expected_recs = {expected_recs, step_recs};
	endfunction

	// ---------------------------------------------------------------
	// record side: random stall, hold-off and the scoreboard
	// ---------------------------------------------------------------
	function automatic string differing_fields(rec_t e, rec_t a);
		string s;
		s = "";
		if (e.record_type !== a.record_type) s = {s, " record_type"};
		if (e.token_kind !== a.token_kind) s = {s, " token_kind"};
		if (e.diag_code !== a.diag_code) s = {s, " diag_code"};
		if (e.start_offset !== a.start_offset) s = {s, " start_offset"};
		if (e.token_length !== a.token_length) s = {s, " token_length"};
		if (e.line_no !== a.line_no) s = {s, " line_no"};
		if (e.column_no !== a.column_no) s = {s, " column_no"};
		if (e.end_line_no !== a.end_line_no) s = {s, " end_line_no"};
		if (e.end_column_no !== a.end_column_no) s = {s, " end_column_no"};
		if (e.offending_char !== a.offending_char) s = {s, " offending_char"};
		if (e.last_of_run !== a.last_of_run) s = {s, " last_of_run"};
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rec_t got, want;
		string bad;
		if (!arst_n) begin
			rec_ready <= 1'b0;
		end else begin
			if (rec_valid && rec_ready) begin
				got = '{record_type, token_kind, diag_code, start_offset, token_length,
					line_no, column_no, end_line_no, end_column_no, offending_char,
					last_of_run};
				if (expected_recs.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected record %p", got);
				end else begin
					want = expected_recs.pop_front();
					bad = differing_fields(want, got);
					if (bad != "") begin
						mismatches++;
						if (mismatches <= 10)
							$display("record mismatch in%s\n  expected %p\n  actual   %p",
								bad, want, got);
					end
				end
			end
			// a long hold-off lets the output queue fill and stall the byte side
			if (hold_seen != hold_seq) begin
				hold_seen <= hold_seq;
				hold_left <= hold_len;
				rec_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rec_ready <= 1'b0;
			end else
				rec_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// byte side
	// ---------------------------------------------------------------
	// offers one request, waits for it to be taken, then predicts it
	task automatic send_item(logic [7:0] b, logic eos);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < src_idle_pct)
				@(posedge clk);
		end
		src_valid <= 1'b1;
		ch <= b;
		end_of_source <= eos;
		do
			@(posedge clk);
		while (!src_ready);
		items_sent++;
		predict_records(b, eos);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	task automatic send_eos();
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// sender pauses until every record has come back, then lets the block settle
	task automatic drain();
		src_valid <= 1'b0;
		while (expected_recs.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic [7:0] pick(string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	// one random lexeme, mostly well formed, sometimes broken or plain noise
	task automatic send_random_lexeme();
		string letters, hexd, punct;
		int k, len;
		letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
		hexd = "0123456789abcdefABCDEFxg";
		punct = ".,:+-*/()[]";
		k = $urandom_range(0, 19);
		case (k)
			0, 1, 2: begin
				send_item(pick(letters), 1'b0);
				len = $urandom_range(0, 6);
				repeat (len) send_item(pick({letters, "0123456789"}), 1'b0);
			end
			3, 4, 5: begin
				if ($urandom_range(0, 2) == 0) send_item(CH_MINUS, 1'b0);
				if ($urandom_range(0, 3) == 0) send_item(CH_DOT, 1'b0);
				repeat ($urandom_range(1, 3)) send_item(pick("0123456789"), 1'b0);
				if ($urandom_range(0, 1)) begin
					send_item(CH_DOT, 1'b0);
					repeat ($urandom_range(0, 2)) send_item(pick("0123456789"), 1'b0);
				end
				if ($urandom_range(0, 1)) begin
					send_item(pick("eE"), 1'b0);
					if ($urandom_range(0, 1)) send_item(pick("+-"), 1'b0);
					repeat ($urandom_range(0, 2)) send_item(pick("0123456789"), 1'b0);
				end
			end
			6, 7, 8: begin
				send_item(CH_QUOTE, 1'b0);
				repeat ($urandom_range(0, 5)) begin
					case ($urandom_range(0, 5))
						0: send_item(CH_BSL, 1'b0);
						1: begin
							send_item(CH_BSL, 1'b0);
							send_item(pick("\"\\/bfnrt"), 1'b0);
						end
						2: begin
							send_item(CH_BSL, 1'b0);
							send_item(CH_LOW_U, 1'b0);
							repeat ($urandom_range(0, 5)) send_item(pick(hexd), 1'b0);
						end
						3: send_item(8'($urandom_range(0, 31)), 1'b0);
						default: send_item(8'($urandom_range(32, 255)), 1'b0);
					endcase
				end
				case ($urandom_range(0, 5))
					0: send_item(CH_LF, 1'b0);
					1: ;
					default: send_item(CH_QUOTE, 1'b0);
				endcase
			end
			9: begin
				if ($urandom_range(0, 1)) send_item(CH_HASH, 1'b0);
				else send_text("//");
				repeat ($urandom_range(0, 5)) send_item(8'($urandom_range(14, 255)), 1'b0);
				send_item(CH_LF, 1'b0);
			end
			10, 11: begin
				case ($urandom_range(0, 2))
					0: send_item(CH_CR, 1'b0);
					1: send_item(CH_LF, 1'b0);
					default: begin
						send_item(CH_CR, 1'b0);
						send_item(CH_LF, 1'b0);
					end
				endcase
			end
			12, 13, 14: send_item(pick(punct), 1'b0);
			15, 16: send_item(pick(" \t"), 1'b0);
			17, 18: send_item(8'($urandom_range(0, 255)), 1'b0);
			default: begin
				if ($urandom_range(0, 1)) send_eos();
				else send_item(CH_SPACE, 1'b0);
			end
		endcase
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------
	// punctuation, invalid bytes, number and string corner cases
	task automatic test_directed();
		send_text(".,:+-*/()[]");
		send_item(8'hff, 1'b0);
		send_item(8'h80, 1'b0);
		send_text("-.5e+ 1.x\"\\u1\\q");
		send_item(8'h01, 1'b0);
		send_item(CH_BSL, 1'b0);
		send_eos();
		send_text("-3E");
		send_eos();
	endtask

	task automatic test_random(int count);
		int target;
		target = items_sent + count;
		while (items_sent < target)
			send_random_lexeme();
		send_eos();
	endtask

	// output held off long enough to fill the queue and stall requests
	task automatic test_backpressure();
		hold_len = 300;
		hold_seq++;
		repeat (40) send_random_lexeme();
		send_eos();
		drain();
	endtask

	initial begin
		clear_scan();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 32;
		rcv_idle_pct = 79;
		test_directed();
		test_random(90);
		drain();

		src_idle_pct = 79;
		rcv_idle_pct = 32;
		test_random(90);
		drain();

		src_idle_pct = 0;
		rcv_idle_pct = 0;
		test_random(60);
		drain();
		test_backpressure();

		if (mismatches == 0 && expected_recs.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
